FILE: hdl/srecord_loader_parser_assert.svh
// assertion macros for the s-record loader checker
`ifndef SRECORD_LOADER_PARSER_ASSERT_SVH
`define SRECORD_LOADER_PARSER_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define SRP_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("srp check failed");

// next-cycle implication, sampled on clk_i, off during reset
`define SRP_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("srp check failed");

`endif

FILE: hdl/srp_pkg.sv
// shared types and constants of the s-record loader
package srp_pkg;

  typedef enum logic [1:0] {
    KIND_WRITE = 2'd0,
    KIND_START = 2'd1,
    KIND_DONE  = 2'd2,
    KIND_ERROR = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ERR_START     = 2'd0,
    ERR_MALFORMED = 2'd1,
    ERR_CHECKSUM  = 2'd2
  } err_e;

  typedef enum logic [1:0] {
    TYPE_S0 = 2'd0,
    TYPE_S1 = 2'd1,
    TYPE_S9 = 2'd2
  } rec_type_e;

  localparam logic [7:0] ChS       = 8'h53;
  localparam logic [7:0] ChNewline = 8'h0A;
  localparam logic [7:0] ChZero    = 8'h30;
  localparam logic [7:0] ChOne     = 8'h31;
  localparam logic [7:0] ChNine    = 8'h39;
  localparam logic [7:0] MinLength = 8'd3;
  localparam logic [7:0] SumGood   = 8'hFF;

  typedef struct packed {
    logic      eof;
    logic      is_s;
    logic      is_nl;
    logic      typ_ok;
    rec_type_e typ;
    logic      hex_ok;
    logic [3:0] nib;
  } token_t;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] address;
    logic [7:0]  data;
    err_e        error_code;
  } result_t;

endpackage

FILE: hdl/srp_front.sv
// character classifier and token queue
module srp_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  output logic            full_o,
  input  logic [7:0]      ch_i,
  input  logic            end_of_file_i,
  output logic            tok_valid_o,
  output srp_pkg::token_t tok_o,
  input  logic            tok_pop_i
);
  import srp_pkg::*;

  token_t     tok_d;
  token_t     tok_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  always_comb begin
    tok_d        = '0;
    tok_d.eof    = end_of_file_i;
    tok_d.is_s   = (ch_i == ChS);
    tok_d.is_nl  = (ch_i == ChNewline);
    tok_d.typ_ok = 1'b1;
    tok_d.typ    = TYPE_S0;
    if (ch_i == ChOne) begin
      tok_d.typ = TYPE_S1;
    end else if (ch_i == ChNine) begin
      tok_d.typ = TYPE_S9;
    end else if (ch_i != ChZero) begin
      tok_d.typ_ok = 1'b0;
    end
    tok_d.hex_ok = 1'b1;
    case (ch_i) inside
      [8'h30:8'h39]: tok_d.nib = ch_i[3:0];
      [8'h41:8'h46], [8'h61:8'h66]: tok_d.nib = ch_i[3:0] + 4'd9;
      default: begin
        tok_d.hex_ok = 1'b0;
        tok_d.nib    = 4'd0;
      end
    endcase
  end

  assign full_o      = (cnt_q == 2'd2);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = tok_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = tok_pop_i && tok_valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      tok_q[wr_ptr_q] <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/srp_back.sv
// record parser state machine and result queue
module srp_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             tok_valid_i,
  input  srp_pkg::token_t  tok_i,
  output logic             tok_pop_o,
  output logic             empty_o,
  input  logic             pop_i,
  output srp_pkg::result_t res_o
);
  import srp_pkg::*;

  typedef enum logic [7:0] {
    PH_START = 8'b0000_0001,
    PH_TYPE  = 8'b0000_0010,
    PH_LEN   = 8'b0000_0100,
    PH_AHI   = 8'b0000_1000,
    PH_ALO   = 8'b0001_0000,
    PH_DATA  = 8'b0010_0000,
    PH_CHECK = 8'b0100_0000,
    PH_EOL   = 8'b1000_0000
  } phase_e;

  phase_e      phase_d, phase_q;
  rec_type_e   type_d, type_q;
  logic [3:0]  hi_d, hi_q;
  logic        pend_d, pend_q;
  logic [7:0]  left_d, left_q;
  logic [15:0] addr_d, addr_q;
  logic [7:0]  sum_d, sum_q;
  logic        halt_d, halt_q;

  logic        emit;
  result_t     res_d;
  logic [7:0]  byte_v, sum_n, left_n;

  result_t     res_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        space, take, do_push, do_pop;

  assign space     = (cnt_q != 2'd2);
  assign take      = tok_valid_i && space;
  assign tok_pop_o = take;
  assign byte_v    = {hi_q, tok_i.nib};
  assign sum_n     = sum_q + byte_v;
  assign left_n    = left_q - 8'd1;

  always_comb begin
    phase_d = phase_q;
    type_d  = type_q;
    hi_d    = hi_q;
    pend_d  = pend_q;
    left_d  = left_q;
    addr_d  = addr_q;
    sum_d   = sum_q;
    halt_d  = halt_q;
    emit    = 1'b0;
    res_d   = '0;
    if (take && !halt_q) begin
      if (tok_i.eof) begin
        halt_d = 1'b1;
        emit   = 1'b1;
        if (phase_q == PH_START || phase_q == PH_EOL) begin
          res_d.kind = KIND_DONE;
        end else begin
          res_d.kind       = KIND_ERROR;
          res_d.error_code = ERR_MALFORMED;
        end
      end else begin
        unique case (phase_q)
          PH_START: begin
            if (!tok_i.is_s) begin
              halt_d     = 1'b1;
              emit       = 1'b1;
              res_d.kind = KIND_ERROR;
            end else begin
              phase_d = PH_TYPE;
            end
          end
          PH_TYPE: begin
            if (!tok_i.typ_ok) begin
              halt_d     = 1'b1;
              emit       = 1'b1;
              res_d.kind = KIND_ERROR;
            end else begin
              type_d  = tok_i.typ;
              sum_d   = 8'd0;
              pend_d  = 1'b0;
              hi_d    = 4'd0;
              left_d  = 8'd0;
              phase_d = PH_LEN;
            end
          end
          PH_EOL: begin
            if (tok_i.is_nl) phase_d = PH_START;
          end
          default: begin
            if (!tok_i.hex_ok) begin
              halt_d           = 1'b1;
              emit             = 1'b1;
              res_d.kind       = KIND_ERROR;
              res_d.error_code = ERR_MALFORMED;
            end else if (!pend_q) begin
              hi_d   = tok_i.nib;
              pend_d = 1'b1;
            end else begin
              pend_d = 1'b0;
              sum_d  = sum_n;
              unique case (phase_q)
                PH_LEN: begin
                  if (byte_v < MinLength) begin
                    halt_d           = 1'b1;
                    emit             = 1'b1;
                    res_d.kind       = KIND_ERROR;
                    res_d.error_code = ERR_MALFORMED;
                  end else begin
                    left_d  = byte_v - MinLength;
                    phase_d = PH_AHI;
                  end
                end
                PH_AHI: begin
                  addr_d  = {byte_v, 8'd0};
                  phase_d = PH_ALO;
                end
                PH_ALO: begin
                  addr_d  = {addr_q[15:8], byte_v};
                  phase_d = (left_q == 8'd0) ? PH_CHECK : PH_DATA;
                end
                PH_DATA: begin
                  left_d = left_n;
                  if (left_n == 8'd0) phase_d = PH_CHECK;
                  if (type_q == TYPE_S1) begin
                    emit          = 1'b1;
                    res_d.kind    = KIND_WRITE;
                    res_d.address = addr_q;
                    res_d.data    = byte_v;
                    addr_d        = addr_q + 16'd1;
                  end
                end
                default: begin
                  phase_d = PH_EOL;
                  if (type_q != TYPE_S0 && sum_n != SumGood) begin
                    halt_d           = 1'b1;
                    emit             = 1'b1;
                    res_d.kind       = KIND_ERROR;
                    res_d.error_code = ERR_CHECKSUM;
                  end else if (type_q == TYPE_S9) begin
                    emit          = 1'b1;
                    res_d.kind    = KIND_START;
                    res_d.address = addr_q;
                  end
                end
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      type_q  <= TYPE_S0;
      hi_q    <= 4'd0;
      pend_q  <= 1'b0;
      left_q  <= 8'd0;
      addr_q  <= 16'd0;
      sum_q   <= 8'd0;
      halt_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      type_q  <= type_d;
      hi_q    <= hi_d;
      pend_q  <= pend_d;
      left_q  <= left_d;
      addr_q  <= addr_d;
      sum_q   <= sum_d;
      halt_q  <= halt_d;
    end
  end

  // result queue
  assign empty_o = (cnt_q == 2'd0);
  assign res_o   = res_q[rd_ptr_q];
  assign do_push = emit;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      res_q[wr_ptr_q] <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) wr_ptr_q <= ~wr_ptr_q;
      if (do_pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({do_push, do_pop})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

FILE: hdl/srecord_loader_parser.sv
// top level of the s-record loader
// Takes one character per cycle and keeps that rate as long as results are popped; a
// character's result passes the classifier queue, then the parser state machine into the
// result queue, before it can be popped. Each side has a two-entry queue,
// so full rises only when the parser is held up by a full result queue. After an error
// or the end-of-file transaction the parser ignores all further characters until reset.
module srecord_loader_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  ch_i,
  input  logic        end_of_file_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [15:0] address_o,
  output logic [7:0]  data_o,
  output logic [1:0]  error_code_o
);
  import srp_pkg::*;

  token_t  tok;
  logic    tok_valid, tok_pop;
  result_t res;

  srp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .full_o        (full),
    .ch_i          (ch_i),
    .end_of_file_i (end_of_file_i),
    .tok_valid_o   (tok_valid),
    .tok_o         (tok),
    .tok_pop_i     (tok_pop)
  );

  srp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign kind_o       = res.kind;
  assign address_o    = res.address;
  assign data_o       = res.data;
  assign error_code_o = res.error_code;

endmodule

FILE: hdl/srp_checker.sv
// port checker for the s-record loader and its bind
`include "srecord_loader_parser_assert.svh"

module srp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        full,
  input logic        empty,
  input logic        pop,
  input logic [1:0]  kind_o,
  input logic [15:0] address_o,
  input logic [7:0]  data_o,
  input logic [1:0]  error_code_o
);
  import srp_pkg::*;

  `SRP_ASSERT_NXT(a_held_result, !empty && !pop, !empty && $stable(kind_o) && $stable(address_o) && $stable(data_o))
  `SRP_ASSERT_NXT(a_last_result, !empty && pop && (kind_o == KIND_ERROR || kind_o == KIND_DONE), empty)
  `SRP_ASSERT_IMP(a_empty_on_pop, $rose(empty), $past(pop))
  `SRP_ASSERT_IMP(a_data_zero, !empty && kind_o != KIND_WRITE, data_o == 8'd0)
  `SRP_ASSERT_IMP(a_full_not_empty, full, !empty)

endmodule

bind srecord_loader_parser srp_checker u_srp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .full         (full),
  .empty        (empty),
  .pop          (pop),
  .kind_o       (kind_o),
  .address_o    (address_o),
  .data_o       (data_o),
  .error_code_o (error_code_o)
);
